// File: hw/rtl/interval_map_table_macros.svh
// Assertion macros for the interval map table
`ifndef INTERVAL_MAP_TABLE_MACROS_SVH
`define INTERVAL_MAP_TABLE_MACROS_SVH
`define IMT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define IMT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// File: hw/rtl/imt_pkg.sv
// Package with shared types and codes of the interval map table
package imt_pkg;
   localparam int KeyWidth   = 16;
   localparam int ValueWidth = 16;

   typedef enum logic [0:0] {
      ACT_ASSIGN = 1'b0,
      ACT_LOOKUP = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic                          action;
      logic signed [KeyWidth-1:0]    range_begin;
      logic signed [KeyWidth-1:0]    range_end;
      logic signed [ValueWidth-1:0]  assign_value;
      logic signed [KeyWidth-1:0]    lookup_key;
   } req_type;

   typedef struct packed {
      logic signed [ValueWidth-1:0]  found_value;
      logic [1:0]                    status;
   } rsp_type;
endpackage

// File: hw/rtl/imt_mem.sv
// Breakpoint memory: one write port, one registered read port
module imt_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int W     = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [W-1:0]  wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [W-1:0]  rd_data
);
   logic [W-1:0] mem_ff [DEPTH];
   logic [W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/interval_map_table.sv
// Top level of the interval map table
// Usage:
//  Requests enter on req_valid/req_stall/req_data; each gives one response on
//  rsp_valid/rsp_stall/rsp_data. The default value must be written via psel
//  at address 0 while the block is idle; the block does not enforce this.
//  The table lives in two memories of MAX_ENTRIES rows (active and scratch),
//  each with one write port and a registered read port.
//  Lookup: a scan of the active memory, 1 row a cycle, over the N stored
//  breakpoints. Assign: a scan that finds the value at range_end, a merge
//  pass that writes the canonical table into the scratch memory, after which
//  the two memories swap roles unless the new table overflows (ST_FULL).
//  Empty ranges answer without a scan.
//  One request is in work at a time; req_stall is high while busy or while a
//  response waits. A stalled response holds its value until taken.
//  Reset clears the breakpoint count, the default and the control state; the
//  memories need no clearing pass, since rows past the count are never used.
`include "interval_map_table_macros.svh"
module interval_map_table #(
   parameter int MAX_ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  imt_pkg::req_type     req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output imt_pkg::rsp_type     rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [1:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 3);
   localparam int KW = imt_pkg::KeyWidth;
   localparam int VW = imt_pkg::ValueWidth;
   localparam int EW = KW + VW;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_MERGE = 6'b000100,
      S_COMMIT= 6'b001000,
      S_RESP  = 6'b010000,
      S_FLUSH = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic signed [VW-1:0] dflt_ff;
   logic [CW-1:0]        count_ff, count_in;
   logic                 sel_ff, sel_in;
   imt_pkg::req_type     req_ff, req_in;
   imt_pkg::rsp_type     rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic signed [VW-1:0] acc_ff, acc_in;
   logic signed [VW-1:0] at_end_ff, at_end_in;
   logic signed [VW-1:0] last_ff, last_in;
   logic [CW-1:0]        wcnt_ff, wcnt_in;
   logic [1:0]           phase_ff, phase_in;

   logic                 accept;
   logic                 csr_wr;
   logic [AW-1:0]        rd_addr;
   logic [EW-1:0]        rd_a, rd_b, rd_cur;
   logic signed [KW-1:0] cur_key;
   logic signed [VW-1:0] cur_val;
   logic                 push_en;
   logic signed [KW-1:0] push_key;
   logic signed [VW-1:0] push_val;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic                 wr_a, wr_b;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && (paddr == 2'd0);
   assign prdata  = (paddr == 2'd0) ? {{(32-VW){dflt_ff[VW-1]}}, dflt_ff} : 32'd0;
   assign accept  = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign rd_cur  = sel_ff ? rd_b : rd_a;
   assign cur_key = rd_cur[EW-1:VW];
   assign cur_val = rd_cur[VW-1:0];
   assign rd_addr = rd_idx_in[AW-1:0];
   assign wr_addr = wcnt_ff[AW-1:0];
   assign wr_en   = push_en && (push_val != last_ff) && (wcnt_ff < CW'(MAX_ENTRIES));
   assign wr_a    = wr_en && sel_ff;
   assign wr_b    = wr_en && !sel_ff;

   imt_mem #(.DEPTH(MAX_ENTRIES), .AW(AW), .W(EW)) u_mem_a (
      .clock(clock), .wr_en(wr_a), .wr_addr(wr_addr), .wr_data({push_key, push_val}),
      .rd_addr(rd_addr), .rd_data(rd_a)
   );
   imt_mem #(.DEPTH(MAX_ENTRIES), .AW(AW), .W(EW)) u_mem_b (
      .clock(clock), .wr_en(wr_b), .wr_addr(wr_addr), .wr_data({push_key, push_val}),
      .rd_addr(rd_addr), .rd_data(rd_b)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sel_in       = sel_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_ptr_ff;
      acc_in       = acc_ff;
      at_end_in    = at_end_ff;
      last_in      = last_ff;
      wcnt_in      = wcnt_ff;
      phase_in     = phase_ff;
      push_en      = 1'b0;
      push_key     = req_ff.range_begin;
      push_val     = req_ff.assign_value;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in    = req_data;
               acc_in    = dflt_ff;
               rd_ptr_in = '0;
               if (req_data.action == imt_pkg::ACT_ASSIGN &&
                   !(req_data.range_begin < req_data.range_end)) begin
                  rsp_in   = '{found_value: '0, status: imt_pkg::ST_EMPTY};
                  state_in = S_RESP;
               end else begin
                  rd_vld_in = (count_ff != '0);
                  rd_ptr_in = CW'(1);
                  rd_idx_in = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (cur_key <= ((req_ff.action == imt_pkg::ACT_LOOKUP) ?
                               req_ff.lookup_key : req_ff.range_end)) begin
                  acc_in = cur_val;
               end
            end
            if (rd_ptr_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = rd_ptr_ff;
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end else if (!rd_vld_ff) begin
               if (req_ff.action == imt_pkg::ACT_LOOKUP) begin
                  rsp_in   = '{found_value: acc_ff, status: imt_pkg::ST_DONE};
                  state_in = S_RESP;
               end else begin
                  at_end_in = acc_ff;
                  last_in   = dflt_ff;
                  wcnt_in   = '0;
                  phase_in  = 2'd0;
                  rd_ptr_in = CW'(1);
                  rd_vld_in = (count_ff != '0);
                  rd_idx_in = '0;
                  state_in  = S_MERGE;
               end
            end
         end
         S_MERGE: begin
            if (rd_vld_ff && phase_ff == 2'd0 && cur_key < req_ff.range_begin) begin
               push_en  = 1'b1;
               push_key = cur_key;
               push_val = cur_val;
            end else if (phase_ff == 2'd0 && (rd_vld_ff || rd_ptr_ff >= count_ff)) begin
               push_en  = 1'b1;
               phase_in = 2'd1;
            end else if (phase_ff == 2'd1) begin
               push_en  = 1'b1;
               push_key = req_ff.range_end;
               push_val = at_end_ff;
               phase_in = 2'd2;
            end else if (rd_vld_ff && phase_ff == 2'd2 && cur_key > req_ff.range_end) begin
               push_en  = 1'b1;
               push_key = cur_key;
               push_val = cur_val;
            end
            if (push_en && push_val != last_ff) begin
               last_in = push_val;
               if (wcnt_ff <= CW'(MAX_ENTRIES)) begin
                  wcnt_in = wcnt_ff + CW'(1);
               end
            end
            if (phase_ff == 2'd0 && rd_vld_ff && !(cur_key < req_ff.range_begin)) begin
               rd_vld_in = 1'b1;
               rd_idx_in = rd_idx_ff;
            end else if (phase_ff == 2'd1) begin
               rd_vld_in = rd_vld_ff;
               rd_idx_in = rd_idx_ff;
            end else if (rd_ptr_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = rd_ptr_ff;
               rd_ptr_in = rd_ptr_ff + CW'(1);
            end else if (!rd_vld_ff && phase_ff == 2'd2) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (wcnt_ff > CW'(MAX_ENTRIES)) begin
               rsp_in = '{found_value: '0, status: imt_pkg::ST_FULL};
            end else begin
               count_in = wcnt_ff;
               sel_in   = !sel_ff;
               rsp_in   = '{found_value: '0, status: imt_pkg::ST_DONE};
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            rsp_valid_in = 1'b1;
            state_in     = S_FLUSH;
         end
         S_FLUSH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dflt_ff      <= '0;
         count_ff     <= '0;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_vld_ff    <= rd_vld_in;
         if (csr_wr) begin
            dflt_ff <= pwdata[VW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      rd_ptr_ff <= rd_ptr_in;
      rd_idx_ff <= rd_idx_in;
      acc_ff    <= acc_in;
      at_end_ff <= at_end_in;
      last_ff   <= last_in;
      wcnt_ff   <= wcnt_in;
      phase_ff  <= phase_in;
   end

   `IMT_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CW'(MAX_ENTRIES))
   `IMT_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != S_IDLE, req_stall)
   `IMT_ASSERT_NEXT(a_commit_resp, clock, reset, state_ff == S_COMMIT, state_ff == S_RESP)
   `IMT_ASSERT_NEXT(a_resp_valid, clock, reset, state_ff == S_RESP, rsp_valid_ff)
endmodule

// File: tb/interval_map_table_test.sv
// Testbench of the interval map table: random and directed requests checked against a predictor
`timescale 1ns / 1ps
module interval_map_table_test;

   localparam int MaxEntries = 64;

   class map_scoreboard;
      logic signed [15:0] keys [MaxEntries];
      logic signed [15:0] vals [MaxEntries];
      int                 count;
      logic signed [15:0] dflt;
      imt_pkg::rsp_type   pending [$];
      int                 errors;

      function void clear();
         count = 0;
         dflt = '0;
         pending.delete();
         errors = 0;
      endfunction

      function logic signed [15:0] value_at(logic signed [15:0] k);
         logic signed [15:0] r;
         r = dflt;
         for (int i = 0; i < count; i++) begin
            if (keys[i] <= k) r = vals[i];
            else break;
         end
         return r;
      endfunction

      function imt_pkg::status_type merge_range(logic signed [15:0] b,
                                                logic signed [15:0] e,
                                                logic signed [15:0] v);
         logic signed [15:0] nk [$];
         logic signed [15:0] nv [$];
         logic signed [15:0] last;
         logic signed [15:0] at_end;
         if (!(b < e)) return imt_pkg::ST_EMPTY;
         at_end = value_at(e);
         last = dflt;
         for (int i = 0; i < count && keys[i] < b; i++)
            if (vals[i] != last) begin
               nk.push_back(keys[i]); nv.push_back(vals[i]); last = vals[i];
            end
         if (v != last) begin
            nk.push_back(b); nv.push_back(v); last = v;
         end
         if (at_end != last) begin
            nk.push_back(e); nv.push_back(at_end); last = at_end;
         end
         for (int i = 0; i < count; i++)
            if (keys[i] > e && vals[i] != last) begin
               nk.push_back(keys[i]); nv.push_back(vals[i]); last = vals[i];
            end
         if (nk.size() > MaxEntries) return imt_pkg::ST_FULL;
         foreach (nk[i]) begin
            keys[i] = nk[i]; vals[i] = nv[i];
         end
         count = nk.size();
         return imt_pkg::ST_DONE;
      endfunction

      function void note_request(imt_pkg::req_type r);
         imt_pkg::rsp_type x;
         if (r.action == imt_pkg::ACT_ASSIGN) begin
            x.found_value = '0;
            x.status = merge_range(r.range_begin, r.range_end, r.assign_value);
         end else begin
            x.found_value = value_at(r.lookup_key);
            x.status = imt_pkg::ST_DONE;
         end
         pending.push_back(x);
      endfunction

      function void check_response(imt_pkg::rsp_type got);
         imt_pkg::rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected response %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.found_value !== want.found_value) begin
            $display("%0t: found_value expected %0d actual %0d", $time,
                     want.found_value, got.found_value);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   imt_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   imt_pkg::rsp_type rsp_data;
   logic             psel;
   logic             penable;
   logic             pwrite;
   logic [1:0]       paddr;
   logic [31:0]      pwdata;
   logic [31:0]      prdata;
   logic             pready;

   map_scoreboard board;
   bit            stall_on;

   interval_map_table u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   initial begin
      board = new();
      board.clear();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      stall_on = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      if (!stall_on) rsp_stall <= 1'b0;
      else case ($urandom_range(0, 3))
         0: rsp_stall <= 1'b1;
         1: rsp_stall <= ($urandom_range(0, 1) == 1);
         default: rsp_stall <= 1'b0;
      endcase
   end

   task automatic send_request(imt_pkg::req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic idle_gap(int n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_default(logic signed [15:0] v);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0;
      pwdata <= {{16{v[15]}}, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      board.dflt = v;
      @(posedge clock);
   endtask

   function automatic imt_pkg::req_type make_assign(int b, int e, int v);
      imt_pkg::req_type r;
      r = '0;
      r.action = imt_pkg::ACT_ASSIGN;
      r.range_begin = b[15:0];
      r.range_end = e[15:0];
      r.assign_value = v[15:0];
      r.lookup_key = 16'($urandom);
      return r;
   endfunction

   function automatic imt_pkg::req_type make_lookup(int k);
      imt_pkg::req_type r;
      r = '0;
      r.action = imt_pkg::ACT_LOOKUP;
      r.range_begin = 16'($urandom);
      r.range_end = 16'($urandom);
      r.assign_value = 16'($urandom);
      r.lookup_key = k[15:0];
      return r;
   endfunction

   function automatic int pick_key(int spread);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 65535) - 32768;
      return $urandom_range(0, spread) - spread / 2;
   endfunction

   task automatic random_phase(int n, int spread);
      int done;
      int burst;
      int b;
      int e;
      done = 0;
      while (done < n) begin
         burst = $urandom_range(1, 12);
         for (int i = 0; i < burst && done < n; i++) begin
            if ($urandom_range(0, 1) == 0) begin
               b = pick_key(spread);
               e = ($urandom_range(0, 7) == 0) ? b - $urandom_range(0, 3)
                                               : b + $urandom_range(1, spread / 4 + 1);
               if (e > 32767) e = 32767;
               send_request(make_assign(b, e, $urandom_range(0, 7) == 0 ? $urandom
                                                : $urandom_range(0, 5) - 2));
            end else begin
               send_request(make_lookup(pick_key(spread)));
            end
            done++;
         end
         if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 15));
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_lookup(-32768));
      send_request(make_assign(-32768, 32767, 16'sh7fff));
      send_request(make_lookup(32767));
      send_request(make_lookup(32766));
      send_request(make_assign(5, 5, 3));
      send_request(make_assign(9, 2, 3));
      send_request(make_assign(-100, 100, -32768));
      send_request(make_lookup(-100));
      send_request(make_lookup(100));
      send_request(make_lookup(-101));
      send_request(make_assign(0, 10, 7));
      send_request(make_assign(10, 20, 7));
      send_request(make_lookup(15));
      send_request(make_assign(-32768, 32767, 0));
      send_request(make_lookup(0));
      for (int i = 0; i < 34; i++) send_request(make_assign(2 * i, 2 * i + 1, i + 1));
      send_request(make_assign(200, 201, 5));
      send_request(make_lookup(33));
      drain();

      write_default(16'sh7fff);
      send_request(make_lookup(-5));
      send_request(make_assign(-32768, 32767, 0));
      drain();
      write_default(16'sh8000);
      stall_on = 1'b1;
      random_phase(150, 400);
      drain();
      write_default(16'sd1);
      random_phase(150, 4000);
      drain();
      write_default(16'sd0);
      stall_on = 1'b0;
      random_phase(75, 200);
      stall_on = 1'b1;
      random_phase(75, 65535);
      drain();

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS interval_map_table");
      end else begin
         $display("FAIL interval_map_table");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("FAIL interval_map_table");
      $finish;
   end
endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/imt_pkg.sv
hw/rtl/imt_mem.sv
hw/rtl/interval_map_table.sv
tb/interval_map_table_test.sv
